// ===== src/gmwf_pkg.sv =====
// shared types and constants for the grid maze wall follower
package gmwf_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_GRID_SIDE  = 3'd0;
  localparam logic [2:0] CFG_START_ROW  = 3'd1;
  localparam logic [2:0] CFG_START_COL  = 3'd2;
  localparam logic [2:0] CFG_END_ROW    = 3'd3;
  localparam logic [2:0] CFG_END_COL    = 3'd4;
  localparam logic [2:0] CFG_MOVE_LIMIT = 3'd5;

  localparam logic [7:0]  GRID_SIDE_RESET  = 8'd128;
  localparam logic [15:0] MOVE_LIMIT_RESET = 16'd10000;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_STEP  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    HD_NORTH = 2'd0,
    HD_EAST  = 2'd1,
    HD_SOUTH = 2'd2,
    HD_WEST  = 2'd3
  } heading_t;

  typedef enum logic [1:0] {
    STAT_IDLE      = 2'd0,
    STAT_MOVED     = 2'd1,
    STAT_ARRIVED   = 2'd2,
    STAT_NO_ENERGY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    WALK_IDLE    = 2'd0,
    WALK_ON      = 2'd1,
    WALK_ARRIVED = 2'd2,
    WALK_OUT     = 2'd3
  } walk_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [6:0] cell_row;
    logic [6:0] cell_col;
    logic       cell_wall;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  heading_moved;
    logic [6:0]  walker_row;
    logic [6:0]  walker_col;
    logic [15:0] moves_made;
  } out_item_t;

  // neighbour candidate from the probe unit
  typedef struct packed {
    logic       ok;
    logic [6:0] row;
    logic [6:0] col;
  } nbr_t;

endpackage

// ===== src/gmwf_ram.sv =====
// generic single-port-write ram with registered read
module gmwf_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/gmwf_nbr.sv =====
// neighbour probe unit: next cell for one heading and its bounds check
module gmwf_nbr import gmwf_pkg::*; (
  input  logic [6:0] pos_row,
  input  logic [6:0] pos_col,
  input  heading_t   heading,
  input  logic [7:0] side,
  output nbr_t       nbr
);

  logic [7:0] nr;
  logic [7:0] nc;
  logic       no_wrap;

  always_comb begin
    nr      = {1'b0, pos_row};
    nc      = {1'b0, pos_col};
    no_wrap = 1'b1;
    case (heading)
      HD_NORTH: begin
        if (pos_row == 7'd0) no_wrap = 1'b0;
        else nr = nr - 8'd1;
      end
      HD_EAST:  nc = nc + 8'd1;
      HD_SOUTH: nr = nr + 8'd1;
      HD_WEST: begin
        if (pos_col == 7'd0) no_wrap = 1'b0;
        else nc = nc - 8'd1;
      end
      default:  no_wrap = 1'b0;
    endcase
    nbr.ok  = no_wrap && (nr < side) && (nc < side);
    nbr.row = nr[6:0];
    nbr.col = nc[6:0];
  end

endmodule

// ===== src/grid_maze_wall_follower.sv =====
// grid maze wall follower: top level with step sequencer and wall map
//
//   channel   signals                          direction  payload
//   in        in_valid, in_stall, in_item      to block   in_item_t
//   out       out_valid, out_stall, out_item   from block out_item_t
//   cfg       cfg_write, cfg_index, cfg_data   to block   16-bit register data
//
// a write or start item goes from accept straight to the result state; a step
// passes through one probe state for each heading tried, plus one wall-map read
// state when the neighbour is in bounds, and then the state that loads the result.
// the single read port of the wall map sets the pace of a step.
// reset (rst, synchronous) restores config registers and walker state; the map is
// not cleared. a held output stalls the block in its result state.
module grid_maze_wall_follower import gmwf_pkg::*; #(
  parameter int MAX_SIDE = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CLOG_SIDE = $clog2(MAX_SIDE);
  localparam int CW        = (CLOG_SIDE > 7) ? 7 : CLOG_SIDE;
  localparam int AW        = 2 * CW;
  localparam int DEPTH     = 2 ** AW;
  localparam int SIDE_CAP  = (MAX_SIDE < 128) ? MAX_SIDE : 128;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_PROBE = 4'b0010,
    S_CHECK = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t      state;
  logic [7:0]  grid_side;
  logic [6:0]  start_row;
  logic [6:0]  start_col;
  logic [6:0]  end_row;
  logic [6:0]  end_col;
  logic [15:0] move_limit;

  logic [6:0]  pos_row;
  logic [6:0]  pos_col;
  heading_t    try_heading;
  logic [15:0] move_count;
  walk_t       walk;
  status_t     res_status;
  heading_t    res_heading;
  logic [1:0]  tries;
  logic [6:0]  cand_row;
  logic [6:0]  cand_col;
  heading_t    cand_head;

  logic [7:0]    side;
  heading_t      probe_head;
  nbr_t          nbr;
  logic          accept;
  logic          emit;
  logic          map_we;
  logic [AW-1:0] map_waddr;
  logic [AW-1:0] map_raddr;
  logic          map_rdata;

  assign side       = (grid_side > 8'(SIDE_CAP)) ? 8'(SIDE_CAP) : grid_side;
  assign probe_head = heading_t'(2'(try_heading + tries));
  assign in_stall   = (state != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign emit       = (state == S_EMIT) && (!out_valid || !out_stall);

  assign map_we    = accept && (in_item.operation == OP_WRITE)
                     && (32'(in_item.cell_row) < MAX_SIDE)
                     && (32'(in_item.cell_col) < MAX_SIDE);
  assign map_waddr = {in_item.cell_row[CW-1:0], in_item.cell_col[CW-1:0]};
  assign map_raddr = {nbr.row[CW-1:0], nbr.col[CW-1:0]};

  gmwf_nbr u_nbr (
    .pos_row (pos_row),
    .pos_col (pos_col),
    .heading (probe_head),
    .side    (side),
    .nbr     (nbr)
  );

  gmwf_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (in_item.cell_wall),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_side  <= GRID_SIDE_RESET;
      start_row  <= 7'd0;
      start_col  <= 7'd0;
      end_row    <= 7'd0;
      end_col    <= 7'd0;
      move_limit <= MOVE_LIMIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_GRID_SIDE:  grid_side  <= cfg_data[7:0];
        CFG_START_ROW:  start_row  <= cfg_data[6:0];
        CFG_START_COL:  start_col  <= cfg_data[6:0];
        CFG_END_ROW:    end_row    <= cfg_data[6:0];
        CFG_END_COL:    end_col    <= cfg_data[6:0];
        CFG_MOVE_LIMIT: move_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer and walker state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      pos_row     <= 7'd0;
      pos_col     <= 7'd0;
      try_heading <= HD_NORTH;
      move_count  <= 16'd0;
      walk        <= WALK_IDLE;
      res_status  <= STAT_IDLE;
      res_heading <= HD_NORTH;
      tries       <= 2'd0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_heading <= HD_NORTH;
            res_status  <= STAT_IDLE;
            state       <= S_EMIT;
            case (in_item.operation)
              OP_START: begin
                pos_row     <= start_row;
                pos_col     <= start_col;
                try_heading <= (start_row == 7'd0) ? HD_NORTH : HD_SOUTH;
                move_count  <= 16'd0;
                if (start_row == end_row && start_col == end_col) begin
                  walk       <= WALK_ARRIVED;
                  res_status <= STAT_ARRIVED;
                end else begin
                  walk <= WALK_ON;
                end
              end
              OP_STEP: begin
                case (walk)
                  WALK_ON: begin
                    tries <= 2'd0;
                    state <= S_PROBE;
                  end
                  WALK_ARRIVED: res_status <= STAT_ARRIVED;
                  WALK_OUT:     res_status <= STAT_NO_ENERGY;
                  default:      res_status <= STAT_IDLE;
                endcase
              end
              default: ;
            endcase
          end
        end
        S_PROBE: begin
          if (nbr.ok) begin
            // wall bit comes back next cycle
            cand_row  <= nbr.row;
            cand_col  <= nbr.col;
            cand_head <= probe_head;
            state     <= S_CHECK;
          end else if (tries == 2'd3) begin
            walk       <= WALK_OUT;
            res_status <= STAT_NO_ENERGY;
            state      <= S_EMIT;
          end else begin
            tries <= tries + 2'd1;
          end
        end
        S_CHECK: begin
          if (!map_rdata) begin
            state <= S_EMIT;
            if (move_count >= move_limit) begin
              walk       <= WALK_OUT;
              res_status <= STAT_NO_ENERGY;
            end else begin
              pos_row     <= cand_row;
              pos_col     <= cand_col;
              move_count  <= move_count + 16'd1;
              try_heading <= heading_t'(2'(cand_head - 2'd1));
              res_heading <= cand_head;
              if (cand_row == end_row && cand_col == end_col) begin
                walk       <= WALK_ARRIVED;
                res_status <= STAT_ARRIVED;
              end else begin
                res_status <= STAT_MOVED;
              end
            end
          end else if (tries == 2'd3) begin
            walk       <= WALK_OUT;
            res_status <= STAT_NO_ENERGY;
            state      <= S_EMIT;
          end else begin
            tries <= tries + 2'd1;
            state <= S_PROBE;
          end
        end
        S_EMIT: begin
          if (emit) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item.status        <= res_status;
      out_item.heading_moved <= res_heading;
      out_item.walker_row    <= pos_row;
      out_item.walker_col    <= pos_col;
      out_item.moves_made    <= move_count;
    end
  end

endmodule
